// ===== rtl/gbts_pkg.sv =====
// Package for the gap buffer text store.
// Holds the store geometry, the command codes and the controller state type.
// No dependencies.
package gbts_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int POS_W = $clog2(CAPACITY + 1);

	localparam logic [2:0] KIND_MOVE = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_BACKSPACE = 3'd2;
	localparam logic [2:0] KIND_DELETE = 3'd3;
	localparam logic [2:0] KIND_READ = 3'd4;

	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MOVE = 3'b010,
		ST_READ = 3'b100
	} state_t;

endpackage

// ===== rtl/gbts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/gap_buffer_text_store.sv =====
// Gap buffer text store: top level with controller and text memory.
// Depends on gbts_pkg and gbts_ram.
//
// Holds up to 1024 bytes of text in one RAM with a gap at the cursor. One command
// is taken at a time. Insert, backspace, delete forward, refused commands and moves
// that leave the cursor in place give their result in the cycle after the transfer.
// A read of a character waits in ST_READ for the RAM's registered read.
// A cursor move copies one byte across the gap per cycle in ST_MOVE,
// reading one entry while writing back the one read before.
// No clearing pass follows reset. The result sits in an output register, so a new
// command is taken in the cycle in which the previous result is transferred.
module gap_buffer_text_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 kind,
	input  logic [gbts_pkg::POS_W-1:0] position,
	input  logic [7:0]                 character,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 read_data,
	output logic                       status,
	output logic [gbts_pkg::POS_W-1:0] text_length,
	output logic [gbts_pkg::POS_W-1:0] cursor
);

	import gbts_pkg::*;

	state_t            state_q, state_n;
	logic [POS_W-1:0]  gs_q, gs_n, ge_q, ge_n, target_q, target_n;
	logic [POS_W-1:0]  len_q, len_n, clamp, idx;
	logic              wr_pend_s1, step;
	logic [ADDR_W-1:0] wr_addr_s1, step_dst;
	logic              ram_we, ins_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic              out_valid_q, out_load, status_n;
	logic [7:0]        data_n;
	logic [7:0]        data_q;
	logic              status_q;
	logic [POS_W-1:0]  tlen_q, cur_q;
	logic              accept;

	assign len_q = CAP_POS - (ge_q - gs_q);
	assign len_n = CAP_POS - (ge_n - gs_n);
	assign clamp = (position > len_q) ? len_q : position;
	assign idx = (position < gs_q) ? position : ge_q + (position - gs_q);
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	always_comb begin
		state_n = state_q;
		gs_n = gs_q;
		ge_n = ge_q;
		target_n = target_q;
		ram_raddr = idx[ADDR_W-1:0];
		ins_we = 1'b0;
		step = 1'b0;
		step_dst = gs_q[ADDR_W-1:0];
		out_load = 1'b0;
		data_n = 8'd0;
		status_n = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_MOVE: begin
							if (clamp == gs_q) begin
								out_load = 1'b1;
							end else begin
								target_n = clamp;
								state_n = ST_MOVE;
							end
						end
						KIND_INSERT: begin
							out_load = 1'b1;
							if (gs_q >= ge_q) begin
								status_n = 1'b1;
							end else begin
								ins_we = 1'b1;
								gs_n = gs_q + 1'b1;
							end
						end
						KIND_BACKSPACE: begin
							out_load = 1'b1;
							if (gs_q == '0) begin
								status_n = 1'b1;
							end else begin
								gs_n = gs_q - 1'b1;
							end
						end
						KIND_DELETE: begin
							out_load = 1'b1;
							if (ge_q >= CAP_POS) begin
								status_n = 1'b1;
							end else begin
								ge_n = ge_q + 1'b1;
							end
						end
						KIND_READ: begin
							if (position >= len_q) begin
								out_load = 1'b1;
								status_n = 1'b1;
							end else begin
								state_n = ST_READ;
							end
						end
						default: begin
							out_load = 1'b1;
							status_n = 1'b1;
						end
					endcase
				end
			end
			ST_MOVE: begin
				if (target_q < gs_q) begin
					step = 1'b1;
					ram_raddr = gs_n[ADDR_W-1:0];
					gs_n = gs_q - 1'b1;
					ge_n = ge_q - 1'b1;
					ram_raddr = gs_n[ADDR_W-1:0];
					step_dst = ge_n[ADDR_W-1:0];
				end else if (target_q > gs_q) begin
					step = 1'b1;
					ram_raddr = ge_q[ADDR_W-1:0];
					step_dst = gs_q[ADDR_W-1:0];
					gs_n = gs_q + 1'b1;
					ge_n = ge_q + 1'b1;
				end else begin
					out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			ST_READ: begin
				out_load = 1'b1;
				data_n = ram_rdata;
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign ram_we = wr_pend_s1 || ins_we;
	assign ram_waddr = wr_pend_s1 ? wr_addr_s1 : gs_q[ADDR_W-1:0];
	assign ram_wdata = wr_pend_s1 ? ram_rdata : character;

	gbts_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_text_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gs_q <= '0;
			ge_q <= CAP_POS;
			wr_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			gs_q <= gs_n;
			ge_q <= ge_n;
			wr_pend_s1 <= step;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		target_q <= target_n;
		wr_addr_s1 <= step_dst;
		if (out_load) begin
			data_q <= data_n;
			status_q <= status_n;
			tlen_q <= len_n;
			cur_q <= gs_n;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = data_q;
	assign status = status_q;
	assign text_length = tlen_q;
	assign cursor = cur_q;

	assert property (@(posedge clk) disable iff (!arst_n) gs_q <= ge_q && ge_q <= CAP_POS)
		else $error("gap bounds broken");
	assert property (@(posedge clk) disable iff (!arst_n) wr_pend_s1 |-> $past(state_q) == ST_MOVE)
		else $error("copy write outside a move");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_READ |=> out_valid_q)
		else $error("read result not registered");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE && target_q == gs_q |=> state_q == ST_IDLE && !wr_pend_s1)
		else $error("move did not finish cleanly");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the gap buffer text store: a predictor keeps its own text
// store and gap, and each result is checked against the oldest expected one.
// Depends on gbts_pkg and gap_buffer_text_store.
module testbench;
	import gbts_pkg::*;

	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int QUIET_LIMIT = 6000;
	localparam int HOLD_OFF = 300;

	typedef struct packed {
		logic [7:0]       read_data;
		logic             status;
		logic [POS_W-1:0] text_length;
		logic [POS_W-1:0] cursor;
	} edit_result_t;

	typedef enum {MIX_TYPE, MIX_EDIT, MIX_ERASE, MIX_FILL} mix_t;

	class text_scoreboard;
		logic [7:0] store [CAPACITY];
		int gap_lo;
		int gap_hi;
		int fails;
		edit_result_t waiting [$];

		function new();
			gap_lo = 0;
			gap_hi = CAPACITY;
			fails = 0;
			foreach (store[i]) store[i] = 8'h00;
		endfunction

		function int text_len();
			return CAPACITY - (gap_hi - gap_lo);
		endfunction

		function int pending();
			return waiting.size();
		endfunction

		// Copy the bytes between old and new cursor across the gap.
		function void shift_gap(int target);
			int n;
			if (target > text_len()) target = text_len();
			if (target < gap_lo) begin
				n = gap_lo - target;
				gap_hi -= n;
				for (int i = n - 1; i >= 0; i--) store[gap_hi + i] = store[target + i];
				gap_lo = target;
			end else if (target > gap_lo) begin
				n = target - gap_lo;
				for (int i = 0; i < n; i++) store[gap_lo + i] = store[gap_hi + i];
				gap_lo += n;
				gap_hi += n;
			end
		endfunction

		function void note_command(logic [2:0] k, logic [POS_W-1:0] p, logic [7:0] c);
			edit_result_t r;
			int pos;
			int idx;
			r = '0;
			pos = int'(p);
			case (k)
				KIND_MOVE: shift_gap(pos);
				KIND_INSERT: begin
					if (gap_lo >= gap_hi) begin
						r.status = 1'b1;
					end else begin
						store[gap_lo] = c;
						gap_lo++;
					end
				end
				KIND_BACKSPACE: begin
					if (gap_lo == 0) r.status = 1'b1;
					else gap_lo--;
				end
				KIND_DELETE: begin
					if (gap_hi >= CAPACITY) r.status = 1'b1;
					else gap_hi++;
				end
				KIND_READ: begin
					if (pos >= text_len()) begin
						r.status = 1'b1;
					end else begin
						idx = (pos < gap_lo) ? pos : gap_hi + (pos - gap_lo);
						if (idx < CAPACITY) r.read_data = store[idx];
					end
				end
				default: r.status = 1'b1;
			endcase
			r.text_length = POS_W'(text_len());
			r.cursor = POS_W'(gap_lo);
			waiting.push_back(r);
		endfunction

		function void check_result(logic [7:0] rd, logic st, logic [POS_W-1:0] len,
				logic [POS_W-1:0] cur);
			edit_result_t e;
			if (waiting.size() == 0) begin
				$error("result transfer with no command outstanding");
				fails++;
				return;
			end
			e = waiting.pop_front();
			if (rd !== e.read_data) begin
				$error("read_data: expected %0d, got %0d", e.read_data, rd);
				fails++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				fails++;
			end
			if (len !== e.text_length) begin
				$error("text_length: expected %0d, got %0d", e.text_length, len);
				fails++;
			end
			if (cur !== e.cursor) begin
				$error("cursor: expected %0d, got %0d", e.cursor, cur);
				fails++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [2:0]       kind;
	logic [POS_W-1:0] position;
	logic [7:0]       character;
	logic             out_valid;
	logic             out_ready;
	logic [7:0]       read_data;
	logic             status;
	logic [POS_W-1:0] text_length;
	logic [POS_W-1:0] cursor;

	text_scoreboard sb = new();
	int sent_count = 0;
	bit send_burst = 0;
	int taken_count = 0;
	bit take_burst = 0;
	int quiet_cycles = 0;

	gap_buffer_text_store DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.position(position),
		.character(character),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status(status),
		.text_length(text_length),
		.cursor(cursor)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_command(kind, position, character);
			if (out_valid && out_ready) sb.check_result(read_data, status, text_length, cursor);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Result side: random stalls, bursts without stalls, and two long hold-offs.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = take_burst ? 0 : $urandom_range(0, 15);
			if (taken_count == 250 || taken_count == 1000) stall = HOLD_OFF;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken_count++;
			if (taken_count % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Start and end at a falling edge; return once the command is transferred.
	task automatic issue(input logic [2:0] k, input logic [POS_W-1:0] p, input logic [7:0] c);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		position <= p;
		character <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent_count++;
		if (sent_count % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
	endtask

	task automatic random_command(input mix_t mix);
		int wm, wi, wb, wd, wr;
		int r, s, len, cur, p;
		logic [2:0] k;
		logic [7:0] c;
		case (mix)
			MIX_TYPE: begin
				wm = 10; wi = 55; wb = 8; wd = 5; wr = 20;
			end
			MIX_EDIT: begin
				wm = 20; wi = 25; wb = 15; wd = 15; wr = 23;
			end
			MIX_ERASE: begin
				wm = 15; wi = 10; wb = 30; wd = 25; wr = 18;
			end
			default: begin
				wm = 5; wi = 85; wb = 0; wd = 0; wr = 10;
			end
		endcase
		len = sb.text_len();
		cur = sb.gap_lo;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		c = 8'($urandom_range(0, 255));
		p = $urandom_range(0, POS_MAX);
		if (r < wm) begin
			k = KIND_MOVE;
			// Keep most moves short; far moves are slow.
			if (s < 70) begin
				p = cur + int'($urandom_range(0, 16)) - 8;
				if (p < 0) p = 0;
			end else if (s < 85) begin
				p = $urandom_range(0, len);
			end else if (s >= 95) begin
				p = (s % 2 == 1) ? len : 0;
			end
		end else if (r < wm + wi) begin
			k = KIND_INSERT;
		end else if (r < wm + wi + wb) begin
			k = KIND_BACKSPACE;
		end else if (r < wm + wi + wb + wd) begin
			k = KIND_DELETE;
		end else if (r < wm + wi + wb + wd + wr) begin
			k = KIND_READ;
			if (s < 70 && len > 0) p = $urandom_range(0, len - 1);
			else if (s < 90) p = len + int'($urandom_range(0, 3));
		end else begin
			k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
		end
		issue(k, POS_W'(p), c);
	endtask

	initial begin
		mix_t mix;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_MOVE;
		position = '0;
		character = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty store: refusals, clamped move and unknown kinds.
		issue(KIND_READ, '0, 8'h00);
		issue(KIND_BACKSPACE, '0, 8'h00);
		issue(KIND_DELETE, '0, 8'h00);
		issue(KIND_MOVE, POS_W'(POS_MAX), 8'hFF);
		for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
			issue(3'(k), POS_W'(POS_MAX), 8'hFF);
		issue(KIND_INSERT, '0, 8'h00);
		issue(KIND_INSERT, POS_W'(POS_MAX), 8'hFF);
		issue(KIND_INSERT, '0, 8'h5A);
		issue(KIND_READ, POS_W'(0), 8'h00);
		issue(KIND_READ, POS_W'(2), 8'h00);
		issue(KIND_READ, POS_W'(3), 8'h00);
		issue(KIND_READ, POS_W'(CAPACITY), 8'h00);
		issue(KIND_MOVE, '0, 8'h00);
		issue(KIND_INSERT, '0, 8'hA5);
		issue(KIND_MOVE, POS_W'(1), 8'h00);
		issue(KIND_DELETE, '0, 8'h00);
		issue(KIND_BACKSPACE, '0, 8'h00);
		issue(KIND_MOVE, POS_W'(CAPACITY), 8'h00);
		issue(KIND_READ, POS_W'(1), 8'h00);
		issue(KIND_MOVE, POS_W'(2), 8'h00);
		issue(KIND_READ, POS_W'(POS_MAX), 8'h00);

		for (int i = 0; i < 300; i++) begin
			if (i % 50 == 0) mix = mix_t'($urandom_range(0, 2));
			random_command(mix);
		end

		// Fill the store, then work on it while full.
		while (sb.text_len() < CAPACITY) random_command(MIX_FILL);
		issue(KIND_INSERT, '0, 8'hC3);
		issue(KIND_READ, POS_W'(CAPACITY - 1), 8'h00);
		issue(KIND_READ, POS_W'(CAPACITY), 8'h00);
		issue(KIND_MOVE, '0, 8'h00);
		issue(KIND_INSERT, '0, 8'h3C);
		issue(KIND_READ, '0, 8'h00);
		issue(KIND_MOVE, POS_W'(POS_MAX), 8'h00);
		issue(KIND_DELETE, '0, 8'h00);
		issue(KIND_MOVE, POS_W'(CAPACITY / 2), 8'h00);
		issue(KIND_READ, POS_W'(CAPACITY / 2), 8'h00);
		repeat (20) random_command(MIX_EDIT);

		for (int i = 0; i < 400; i++) begin
			if (i % 50 == 0) mix = ($urandom_range(0, 1) == 0) ? MIX_ERASE : MIX_EDIT;
			random_command(mix);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/gbts_pkg.sv
rtl/gbts_ram.sv
rtl/gap_buffer_text_store.sv
sim/testbench.sv
